### src/ndt_pkg.sv
// ndt_pkg: shared constants, codes and structs of the node device table
// no dependencies; used by every other file of the block
package ndt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam int NODE_W = 16;
   localparam int TIME_W = 32;
   localparam int MODEL_W = 40;
   localparam int MODEL_BYTES = 5;
   localparam int LEN_W = 8;
   localparam int INDEX_W = 8;
   localparam int FUNC_W = 3;
   localparam int KIND_W = 2;
   localparam int STATE_W = 2;
   localparam int COUNT_W = 5;

   localparam logic [NODE_W-1:0] NODE_INVALID = 16'hFFFF;
   localparam logic [NODE_W-1:0] NODE_COORD = 16'h0000;

   // model strings, byte 0 in the low bits
   localparam logic [MODEL_W-1:0] MODEL_HC = 40'h00_0000_4348;
   localparam logic [MODEL_W-1:0] MODEL_REM = 40'h00_004D_4552;
   localparam logic [MODEL_W-1:0] MODEL_QUAT = 40'h00_5441_5551;

   // device state codes on the result
   localparam logic [STATE_W-1:0] STATE_OFFLINE = 2'd0;
   localparam logic [STATE_W-1:0] STATE_ONLINE = 2'd1;
   localparam logic [STATE_W-1:0] STATE_UNKNOWN = 2'd2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD = 3'd0,
      FUNC_DELETE = 3'd1,
      FUNC_READ = 3'd2,
      FUNC_LOOKUP = 3'd3,
      FUNC_ONLINE = 3'd4,
      FUNC_OFFLINE = 3'd5,
      FUNC_TIME = 3'd6
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_UNQUAL = 2'd0,
      KIND_HC = 2'd1,
      KIND_REM = 2'd2,
      KIND_QUAT = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_SCAN,
      S_HIT,
      S_SHIFT,
      S_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      kind_type kind;
      logic online;
      logic [TIME_W-1:0] seen;
   } entry_type;

   typedef struct packed {
      logic en;
      logic [IDX_W-1:0] addr;
      entry_type entry;
   } store_wr_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [NODE_W-1:0] node_id;
      logic [INDEX_W-1:0] entry_index;
      logic [TIME_W-1:0] time_value;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] dev_node;
      logic [KIND_W-1:0] dev_type;
      logic [STATE_W-1:0] dev_state;
      logic [TIME_W-1:0] dev_time;
      logic ok;
      logic [COUNT_W-1:0] count;
   } result_type;

endpackage

### src/ndt_if.sv
// ndt_req_if and ndt_rsp_if: valid/ready channels of the node device table
// widths from ndt_pkg
interface ndt_req_if;
   logic valid;
   logic ready;
   logic [ndt_pkg::FUNC_W-1:0] func;
   logic [ndt_pkg::NODE_W-1:0] node_id;
   logic [ndt_pkg::MODEL_W-1:0] model_bytes;
   logic [ndt_pkg::LEN_W-1:0] model_len;
   logic model_present;
   logic [ndt_pkg::INDEX_W-1:0] entry_index;
   logic [ndt_pkg::TIME_W-1:0] time_value;

   modport source (
      output valid, func, node_id, model_bytes, model_len, model_present,
             entry_index, time_value,
      input ready
   );
   modport sink (
      input valid, func, node_id, model_bytes, model_len, model_present,
            entry_index, time_value,
      output ready
   );
endinterface

interface ndt_rsp_if;
   logic valid;
   logic ready;
   logic [ndt_pkg::NODE_W-1:0] dev_node;
   logic [ndt_pkg::KIND_W-1:0] dev_type;
   logic [ndt_pkg::STATE_W-1:0] dev_state;
   logic [ndt_pkg::TIME_W-1:0] dev_time;
   logic ok;
   logic [ndt_pkg::COUNT_W-1:0] count;

   modport source (
      output valid, dev_node, dev_type, dev_state, dev_time, ok, count,
      input ready
   );
   modport sink (
      input valid, dev_node, dev_type, dev_state, dev_time, ok, count,
      output ready
   );
endinterface

### src/node_device_table_unit.sv
// node_device_table_unit: top level of the node device table
// uses ndt_pkg, ndt_if, ndt_class, ndt_store, ndt_ctrl
//
//   channel   dir   handshake        payload
//   req_ch    in    valid / ready    func, node_id, model_bytes, model_len,
//                                    model_present, entry_index, time_value
//   rsp_ch    out   valid / ready    dev_node, dev_type, dev_state, dev_time, ok, count
//
// one operation at a time; a node-id search walks the filled entries through
// one shared compare, one entry per cycle, and delete adds a move pass over
// the entries behind the deleted one
// add into an empty table and read by position need no search
// synchronous reset empties the table (entry count to 0), no clearing pass
// the result sits in an output register; a stalled rsp_ch holds the result
// and the next request is taken once the sequencer is back in idle
module node_device_table_unit (
   input logic clock,
   input logic reset,
   ndt_req_if.sink req_ch,
   ndt_rsp_if.source rsp_ch
);

   ndt_pkg::req_type req;
   ndt_pkg::kind_type req_kind;
   logic req_ready;
   logic res_valid;
   logic res_take;
   ndt_pkg::result_type res;
   ndt_pkg::store_wr_type wr;
   logic [ndt_pkg::IDX_W-1:0] rd_addr;
   ndt_pkg::entry_type rd_entry;

   logic rsp_valid_ff, rsp_valid_in;
   ndt_pkg::result_type rsp_data_ff, rsp_data_in;

   // request payload as a struct for the sequencer
   assign req.func = req_ch.func;
   assign req.node_id = req_ch.node_id;
   assign req.entry_index = req_ch.entry_index;
   assign req.time_value = req_ch.time_value;
   assign req_ch.ready = req_ready;

   // model string sorted at the request transfer, latched by the sequencer
   ndt_class u_class (
      .model_bytes(req_ch.model_bytes),
      .model_len(req_ch.model_len),
      .model_present(req_ch.model_present),
      .kind(req_kind)
   );

   ndt_store u_store (
      .clock(clock),
      .wr(wr),
      .rd_addr(rd_addr),
      .rd_entry(rd_entry)
   );

   ndt_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req(req),
      .req_kind(req_kind),
      .req_ready(req_ready),
      .res_valid(res_valid),
      .res(res),
      .res_take(res_take),
      .wr(wr),
      .rd_addr(rd_addr),
      .rd_entry(rd_entry)
   );

   // output register: loads when empty or when its result leaves this cycle
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = res;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.dev_node = rsp_data_ff.dev_node;
   assign rsp_ch.dev_type = rsp_data_ff.dev_type;
   assign rsp_ch.dev_state = rsp_data_ff.dev_state;
   assign rsp_ch.dev_time = rsp_data_ff.dev_time;
   assign rsp_ch.ok = rsp_data_ff.ok;
   assign rsp_ch.count = rsp_data_ff.count;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled result changed");

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      res_take |-> !req_ready)
      else $error("result loaded while sequencer idle");

   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      res_take |=> rsp_valid_ff)
      else $error("loaded result not shown");

endmodule

### src/ndt_store.sv
// ndt_store: entry storage, one write port and one registered read port
// uses ndt_pkg types
module ndt_store (
   input  logic clock,
   input  ndt_pkg::store_wr_type wr,
   input  logic [ndt_pkg::IDX_W-1:0] rd_addr,
   output ndt_pkg::entry_type rd_entry
);

   ndt_pkg::entry_type mem [ndt_pkg::TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      rd_entry <= mem[rd_addr];
   end

endmodule

### src/ndt_class.sv
// ndt_class: sorts a model string into a device kind, prefix compare with limit
// uses ndt_pkg constants
module ndt_class (
   input  logic [ndt_pkg::MODEL_W-1:0] model_bytes,
   input  logic [ndt_pkg::LEN_W-1:0] model_len,
   input  logic model_present,
   output ndt_pkg::kind_type kind
);

   function automatic logic model_match(
      input logic [ndt_pkg::MODEL_W-1:0] bytes,
      input logic [ndt_pkg::LEN_W-1:0] limit,
      input logic [ndt_pkg::MODEL_W-1:0] lit
   );
      logic match;
      logic stop;
      logic [7:0] a;
      match = 1'b1;
      stop = 1'b0;
      for (int i = 0; i < ndt_pkg::MODEL_BYTES; i++) begin
         a = bytes[8*i +: 8];
         if (!stop && (ndt_pkg::LEN_W'(i) < limit)) begin
            if (a != lit[8*i +: 8]) begin
               match = 1'b0;
               stop = 1'b1;
            end else if (a == 8'h00) begin
               stop = 1'b1;
            end
         end
      end
      return match;
   endfunction

   always_comb begin
      priority if (!model_present) begin
         kind = ndt_pkg::KIND_UNQUAL;
      end else if (model_match(model_bytes, model_len, ndt_pkg::MODEL_HC)) begin
         kind = ndt_pkg::KIND_HC;
      end else if (model_match(model_bytes, model_len, ndt_pkg::MODEL_REM)) begin
         kind = ndt_pkg::KIND_REM;
      end else if (model_match(model_bytes, model_len, ndt_pkg::MODEL_QUAT)) begin
         kind = ndt_pkg::KIND_QUAT;
      end else begin
         kind = ndt_pkg::KIND_UNQUAL;
      end
   end

endmodule

### src/ndt_ctrl.sv
// ndt_ctrl: sequencer with the shared node-id compare, scan and move passes
// uses ndt_pkg; drives the ndt_store ports
module ndt_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  ndt_pkg::req_type req,
   input  ndt_pkg::kind_type req_kind,
   output logic req_ready,
   output logic res_valid,
   output ndt_pkg::result_type res,
   input  logic res_take,
   output ndt_pkg::store_wr_type wr,
   output logic [ndt_pkg::IDX_W-1:0] rd_addr,
   input  ndt_pkg::entry_type rd_entry
);

   ndt_pkg::ctrl_state_type state_ff, state_in;
   ndt_pkg::func_type func_ff, func_in;
   logic [ndt_pkg::NODE_W-1:0] node_ff, node_in;
   ndt_pkg::kind_type kind_ff, kind_in;
   logic [ndt_pkg::INDEX_W-1:0] index_ff, index_in;
   logic [ndt_pkg::TIME_W-1:0] time_ff, time_in;
   logic [ndt_pkg::CNT_W-1:0] scan_ff, scan_in;
   logic [ndt_pkg::CNT_W-1:0] count_ff, count_in;
   ndt_pkg::result_type res_ff, res_in;

   logic req_fire;
   logic [ndt_pkg::CNT_W-1:0] scan_nxt;
   logic [ndt_pkg::CNT_W-1:0] rd_next;
   logic scan_end;
   logic node_hit;
   logic index_ok;
   logic table_full;
   logic move_more;
   ndt_pkg::entry_type new_entry;
   ndt_pkg::entry_type mod_entry;

   function automatic ndt_pkg::result_type make_res(
      input logic [ndt_pkg::NODE_W-1:0] node,
      input logic [ndt_pkg::KIND_W-1:0] kind,
      input logic [ndt_pkg::STATE_W-1:0] st,
      input logic [ndt_pkg::TIME_W-1:0] seen,
      input logic ok,
      input logic [ndt_pkg::CNT_W-1:0] cnt
   );
      ndt_pkg::result_type r;
      r.dev_node = node;
      r.dev_type = kind;
      r.dev_state = st;
      r.dev_time = seen;
      r.ok = ok;
      r.count = ndt_pkg::COUNT_W'(cnt);
      return r;
   endfunction

   function automatic ndt_pkg::result_type entry_res(
      input ndt_pkg::entry_type e,
      input logic [ndt_pkg::CNT_W-1:0] cnt
   );
      return make_res(e.node, e.kind, {1'b0, e.online}, e.seen, 1'b1, cnt);
   endfunction

   function automatic ndt_pkg::result_type invalid_res(
      input logic [ndt_pkg::CNT_W-1:0] cnt
   );
      return make_res(ndt_pkg::NODE_INVALID, ndt_pkg::KIND_UNQUAL,
                      ndt_pkg::STATE_OFFLINE, '0, 1'b0, cnt);
   endfunction

   assign req_ready = (state_ff == ndt_pkg::S_IDLE);
   assign req_fire = req_valid && req_ready;
   assign res_valid = (state_ff == ndt_pkg::S_DONE);
   assign res = res_ff;

   assign scan_nxt = scan_ff + 1'b1;
   assign scan_end = (scan_ff >= count_ff);
   assign node_hit = (rd_entry.node == node_ff);
   assign index_ok = (index_ff < ndt_pkg::INDEX_W'(count_ff));
   assign table_full = (count_ff >= ndt_pkg::CNT_W'(ndt_pkg::TABLE_DEPTH));
   assign move_more = (scan_nxt < count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ndt_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = ndt_pkg::S_START;
            end
         end
         ndt_pkg::S_START: begin
            unique case (func_ff)
               ndt_pkg::FUNC_ADD: begin
                  state_in = (count_ff == '0) ? ndt_pkg::S_DONE : ndt_pkg::S_SCAN;
               end
               ndt_pkg::FUNC_READ: begin
                  state_in = index_ok ? ndt_pkg::S_HIT : ndt_pkg::S_DONE;
               end
               ndt_pkg::FUNC_DELETE, ndt_pkg::FUNC_LOOKUP, ndt_pkg::FUNC_ONLINE,
               ndt_pkg::FUNC_OFFLINE, ndt_pkg::FUNC_TIME: begin
                  state_in = ndt_pkg::S_SCAN;
               end
               default: begin
                  state_in = ndt_pkg::S_DONE;
               end
            endcase
         end
         ndt_pkg::S_SCAN: begin
            priority if (scan_end) begin
               state_in = ndt_pkg::S_DONE;
            end else if (node_hit) begin
               state_in = ndt_pkg::S_HIT;
            end
         end
         ndt_pkg::S_HIT: begin
            state_in = (func_ff == ndt_pkg::FUNC_DELETE) ? ndt_pkg::S_SHIFT
                                                          : ndt_pkg::S_DONE;
         end
         ndt_pkg::S_SHIFT: begin
            if (!move_more) begin
               state_in = ndt_pkg::S_DONE;
            end
         end
         ndt_pkg::S_DONE: begin
            if (res_take) begin
               state_in = ndt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ndt_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and store control
   always_comb begin
      func_in = func_ff;
      node_in = node_ff;
      kind_in = kind_ff;
      index_in = index_ff;
      time_in = time_ff;
      scan_in = scan_ff;
      count_in = count_ff;
      res_in = res_ff;
      wr = '0;

      new_entry.node = node_ff;
      new_entry.kind = kind_ff;
      new_entry.online = 1'b1;
      new_entry.seen = '0;

      mod_entry = rd_entry;
      unique case (func_ff)
         ndt_pkg::FUNC_ONLINE: mod_entry.online = 1'b1;
         ndt_pkg::FUNC_OFFLINE: mod_entry.online = 1'b0;
         ndt_pkg::FUNC_TIME: mod_entry.seen = time_ff;
         default: mod_entry = rd_entry;
      endcase

      unique case (state_ff)
         ndt_pkg::S_IDLE: begin
            if (req_fire) begin
               func_in = ndt_pkg::func_type'(req.func);
               node_in = req.node_id;
               kind_in = req_kind;
               index_in = req.entry_index;
               time_in = req.time_value;
               scan_in = '0;
            end
         end
         ndt_pkg::S_START: begin
            unique case (func_ff)
               ndt_pkg::FUNC_ADD: begin
                  // first add always puts the coordinator in slot 0
                  if (count_ff == '0) begin
                     wr.en = 1'b1;
                     wr.addr = '0;
                     wr.entry.node = ndt_pkg::NODE_COORD;
                     wr.entry.kind = ndt_pkg::KIND_HC;
                     wr.entry.online = 1'b1;
                     wr.entry.seen = '0;
                     count_in = ndt_pkg::CNT_W'(1);
                     res_in = make_res(ndt_pkg::NODE_COORD, ndt_pkg::KIND_HC,
                                       ndt_pkg::STATE_ONLINE, '0, 1'b1,
                                       ndt_pkg::CNT_W'(1));
                  end
               end
               ndt_pkg::FUNC_READ: begin
                  if (index_ok) begin
                     scan_in = index_ff[ndt_pkg::CNT_W-1:0];
                  end else begin
                     res_in = invalid_res(count_ff);
                  end
               end
               ndt_pkg::FUNC_DELETE, ndt_pkg::FUNC_LOOKUP, ndt_pkg::FUNC_ONLINE,
               ndt_pkg::FUNC_OFFLINE, ndt_pkg::FUNC_TIME: begin
                  scan_in = '0;
               end
               default: begin
                  res_in = invalid_res(count_ff);
               end
            endcase
         end
         ndt_pkg::S_SCAN: begin
            if (scan_end) begin
               unique case (func_ff)
                  ndt_pkg::FUNC_ADD: begin
                     priority if (node_ff == ndt_pkg::NODE_INVALID) begin
                        res_in = make_res(ndt_pkg::NODE_INVALID, kind_ff,
                                          ndt_pkg::STATE_ONLINE, '0, 1'b0, count_ff);
                     end else if (table_full) begin
                        res_in = invalid_res(count_ff);
                     end else begin
                        wr.en = 1'b1;
                        wr.addr = count_ff[ndt_pkg::IDX_W-1:0];
                        wr.entry = new_entry;
                        count_in = count_ff + 1'b1;
                        res_in = entry_res(new_entry, count_ff + 1'b1);
                     end
                  end
                  ndt_pkg::FUNC_LOOKUP: begin
                     res_in = make_res(ndt_pkg::NODE_INVALID, ndt_pkg::KIND_UNQUAL,
                                       ndt_pkg::STATE_UNKNOWN, '0, 1'b0, count_ff);
                  end
                  default: begin
                     res_in = invalid_res(count_ff);
                  end
               endcase
            end else if (!node_hit) begin
               scan_in = scan_nxt;
            end
         end
         ndt_pkg::S_HIT: begin
            unique case (func_ff)
               ndt_pkg::FUNC_ADD: begin
                  res_in = invalid_res(count_ff);
               end
               ndt_pkg::FUNC_DELETE: begin
                  res_in = entry_res(rd_entry, count_ff - 1'b1);
               end
               ndt_pkg::FUNC_READ, ndt_pkg::FUNC_LOOKUP: begin
                  res_in = entry_res(rd_entry, count_ff);
               end
               ndt_pkg::FUNC_ONLINE, ndt_pkg::FUNC_OFFLINE, ndt_pkg::FUNC_TIME: begin
                  wr.en = 1'b1;
                  wr.addr = scan_ff[ndt_pkg::IDX_W-1:0];
                  wr.entry = mod_entry;
                  res_in = entry_res(mod_entry, count_ff);
               end
               default: begin
                  res_in = invalid_res(count_ff);
               end
            endcase
         end
         ndt_pkg::S_SHIFT: begin
            // close the gap, one entry per cycle
            if (move_more) begin
               wr.en = 1'b1;
               wr.addr = scan_ff[ndt_pkg::IDX_W-1:0];
               wr.entry = rd_entry;
               scan_in = scan_nxt;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ndt_pkg::S_DONE: begin
         end
         default: begin
         end
      endcase

      // registered store read: address the entry the next cycle works on
      rd_next = (state_in == ndt_pkg::S_SHIFT) ? scan_in + 1'b1 : scan_in;
      rd_addr = rd_next[ndt_pkg::IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ndt_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      node_ff <= node_in;
      kind_ff <= kind_in;
      index_ff <= index_in;
      time_ff <= time_in;
      scan_ff <= scan_in;
      res_ff <= res_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ndt_pkg::CNT_W'(ndt_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ndt_pkg::S_SHIFT) |-> (scan_ff < count_ff))
      else $error("move pass outside the filled entries");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> ($past(state_ff) == ndt_pkg::S_START ||
                              $past(state_ff) == ndt_pkg::S_SCAN ||
                              $past(state_ff) == ndt_pkg::S_SHIFT))
      else $error("entry count changed outside add or delete");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ndt_pkg::S_IDLE || state_ff == ndt_pkg::S_DONE) |-> !wr.en)
      else $error("store written while no operation runs");

endmodule

### test/ndt_table_checker.sv
// ndt_table_checker: watches both channels of the node device table, keeps its own copy
// of the table and compares every result transfer field by field
// depends on ndt_pkg and the ndt_req_if / ndt_rsp_if interfaces
module ndt_table_checker
   import ndt_pkg::*;
(
   input logic clock,
   input logic reset,
   ndt_req_if req_ch,
   ndt_rsp_if rsp_ch,
   output int fail_count,
   output int pending
);
   timeunit 1ns;
   timeprecision 1ps;

   entry_type tbl_entry [TABLE_DEPTH];
   int tbl_count;
   result_type results_due [$];

   // strncmp against a literal, at most five bytes
   function automatic bit model_is(logic [MODEL_W-1:0] bytes, logic [LEN_W-1:0] len,
                                   logic [MODEL_W-1:0] lit);
      int i;
      logic [7:0] a;
      for (i = 0; i < int'(len) && i < MODEL_BYTES; i++) begin
         a = bytes[8*i +: 8];
         if (a != lit[8*i +: 8]) return 1'b0;
         if (a == 8'd0) return 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic kind_type classify_model(logic [MODEL_W-1:0] bytes,
                                               logic [LEN_W-1:0] len, logic present);
      if (!present) return KIND_UNQUAL;
      if (model_is(bytes, len, MODEL_HC)) return KIND_HC;
      if (model_is(bytes, len, MODEL_REM)) return KIND_REM;
      if (model_is(bytes, len, MODEL_QUAT)) return KIND_QUAT;
      return KIND_UNQUAL;
   endfunction

   function automatic int find_node(logic [NODE_W-1:0] node);
      int i;
      for (i = 0; i < tbl_count; i++)
         if (tbl_entry[i].node == node) return i;
      return -1;
   endfunction

   function automatic result_type make_result(logic [NODE_W-1:0] node, logic [KIND_W-1:0] kind,
                                              logic [STATE_W-1:0] state,
                                              logic [TIME_W-1:0] seen, logic ok);
      result_type r;
      r.dev_node = node;
      r.dev_type = kind;
      r.dev_state = state;
      r.dev_time = seen;
      r.ok = ok;
      r.count = COUNT_W'(tbl_count);
      return r;
   endfunction

   function automatic result_type entry_result(entry_type e);
      return make_result(e.node, e.kind, e.online ? STATE_ONLINE : STATE_OFFLINE, e.seen, 1'b1);
   endfunction

   function automatic result_type invalid_result();
      return make_result(NODE_INVALID, KIND_UNQUAL, STATE_OFFLINE, '0, 1'b0);
   endfunction

   // applies one operation to the table copy and returns the device result it gives
   function automatic result_type table_operation(logic [FUNC_W-1:0] func,
                                                  logic [NODE_W-1:0] node,
                                                  logic [MODEL_W-1:0] model,
                                                  logic [LEN_W-1:0] len, logic present,
                                                  logic [INDEX_W-1:0] index,
                                                  logic [TIME_W-1:0] value);
      int slot;
      int i;
      kind_type kind;
      entry_type gone;
      case (func)
         FUNC_ADD: begin
            // first add into an empty table is always the coordinator
            if (tbl_count == 0) begin
               node = NODE_COORD;
               kind = KIND_HC;
            end else begin
               if (find_node(node) >= 0) return invalid_result();
               kind = classify_model(model, len, present);
               if (node == NODE_INVALID)
                  return make_result(NODE_INVALID, kind, STATE_ONLINE, '0, 1'b0);
            end
            if (tbl_count >= TABLE_DEPTH) return invalid_result();
            slot = tbl_count;
            tbl_entry[slot].node = node;
            tbl_entry[slot].kind = kind;
            tbl_entry[slot].online = 1'b1;
            tbl_entry[slot].seen = '0;
            tbl_count++;
            return entry_result(tbl_entry[slot]);
         end
         FUNC_DELETE: begin
            slot = find_node(node);
            if (slot < 0) return invalid_result();
            gone = tbl_entry[slot];
            for (i = slot; i + 1 < tbl_count; i++)
               tbl_entry[i] = tbl_entry[i + 1];
            tbl_count--;
            return entry_result(gone);
         end
         FUNC_READ: begin
            if (int'(index) >= tbl_count) return invalid_result();
            return entry_result(tbl_entry[index]);
         end
         FUNC_LOOKUP: begin
            slot = find_node(node);
            if (slot < 0) return make_result(NODE_INVALID, KIND_UNQUAL, STATE_UNKNOWN, '0, 1'b0);
            return entry_result(tbl_entry[slot]);
         end
         FUNC_ONLINE, FUNC_OFFLINE, FUNC_TIME: begin
            slot = find_node(node);
            if (slot < 0) return invalid_result();
            if (func == FUNC_ONLINE) tbl_entry[slot].online = 1'b1;
            else if (func == FUNC_OFFLINE) tbl_entry[slot].online = 1'b0;
            else tbl_entry[slot].seen = value;
            return entry_result(tbl_entry[slot]);
         end
         default: return invalid_result();
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
      $display("t=%0d ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      result_type got;
      result_type want;
      if (reset) begin
         tbl_count = 0;
         results_due.delete();
      end else begin
         // result first: the next request may be taken at the same edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.dev_node = rsp_ch.dev_node;
            got.dev_type = rsp_ch.dev_type;
            got.dev_state = rsp_ch.dev_state;
            got.dev_time = rsp_ch.dev_time;
            got.ok = rsp_ch.ok;
            got.count = rsp_ch.count;
            if (results_due.size() == 0) begin
               report_mismatch("result with nothing due, dev_node", '0,
                               TIME_W'(got.dev_node));
            end else begin
               want = results_due.pop_front();
               if (got.dev_node !== want.dev_node)
                  report_mismatch("dev_node", TIME_W'(want.dev_node), TIME_W'(got.dev_node));
               if (got.dev_type !== want.dev_type)
                  report_mismatch("dev_type", TIME_W'(want.dev_type), TIME_W'(got.dev_type));
               if (got.dev_state !== want.dev_state)
                  report_mismatch("dev_state", TIME_W'(want.dev_state),
                                  TIME_W'(got.dev_state));
               if (got.dev_time !== want.dev_time)
                  report_mismatch("dev_time", want.dev_time, got.dev_time);
               if (got.ok !== want.ok)
                  report_mismatch("ok", TIME_W'(want.ok), TIME_W'(got.ok));
               if (got.count !== want.count)
                  report_mismatch("count", TIME_W'(want.count), TIME_W'(got.count));
            end
         end
         if (req_ch.valid && req_ch.ready)
            results_due.push_back(table_operation(req_ch.func, req_ch.node_id,
                                                  req_ch.model_bytes, req_ch.model_len,
                                                  req_ch.model_present, req_ch.entry_index,
                                                  req_ch.time_value));
      end
      pending = results_due.size();
   end

endmodule

### test/tb_node_device_table_unit.sv
// tb_node_device_table_unit: drives requests into the node device table, takes its results
// with random stalls, and gives the verdict from the checker's failure count
// depends on ndt_pkg, the channel interfaces, node_device_table_unit and ndt_table_checker
module tb_node_device_table_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import ndt_pkg::*;

   localparam int CLOCK_PERIOD = 2;
   localparam int RESET_CYCLES = 6;
   localparam int IDLE_MAX = 10;
   // the one func code the block leaves unused
   localparam logic [FUNC_W-1:0] FUNC_RESERVED = 3'd7;
   // long receiver hold-off so the output register fills and the input stalls
   localparam int HOLD_AT = 150;
   localparam int HOLD_CYCLES = 400;
   // a delete walks to the entry and moves the rest down
   localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 32;
   localparam int PHASE_ITEMS = 100;
   localparam int POOL_SIZE = 24;
   localparam int TIMEOUT_NS = 400_000;

   // one request, as the sender puts it on the channel
   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [NODE_W-1:0] node;
      logic [MODEL_W-1:0] model;
      logic [LEN_W-1:0] len;
      logic present;
      logic [INDEX_W-1:0] index;
      logic [TIME_W-1:0] value;
   } op_item;

   logic clock = 1'b0;
   logic reset;
   logic no_idle = 1'b0;
   int fail_count;
   int pending;
   logic [NODE_W-1:0] node_pool [POOL_SIZE];

   // per phase mix: share of adds and deletes in percent
   int add_pct [4] = '{60, 30, 10, 35};
   int del_pct [4] = '{5, 15, 50, 20};

   ndt_req_if req_ch ();
   ndt_rsp_if rsp_ch ();

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   node_device_table_unit u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ndt_table_checker u_checker (
      .clock (clock),
      .reset (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .fail_count (fail_count),
      .pending (pending)
   );

   // hard stop in case the block hangs or a result never shows up
   initial begin
      #(TIMEOUT_NS);
      $display("simulation failed");
      $finish;
   end

   // offer one request after a random gap and hold it until the transfer
   task automatic send_op(op_item it);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= it.func;
      req_ch.node_id <= it.node;
      req_ch.model_bytes <= it.model;
      req_ch.model_len <= it.len;
      req_ch.model_present <= it.present;
      req_ch.entry_index <= it.index;
      req_ch.time_value <= it.value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // random request: node ids mostly from a small pool so that hits, duplicates
   // and a full table come up often
   function automatic op_item random_op(int adds, int dels);
      op_item it;
      int pick;
      logic [63:0] wide;
      logic [MODEL_W-1:0] lit;
      logic [MODEL_W-1:0] mask;
      pick = $urandom_range(0, 99);
      if (pick < adds) begin
         it.func = FUNC_ADD;
      end else if (pick < adds + dels) begin
         it.func = FUNC_DELETE;
      end else begin
         case ($urandom_range(0, 10))
            0, 1: it.func = FUNC_READ;
            2, 3: it.func = FUNC_LOOKUP;
            4, 5: it.func = FUNC_ONLINE;
            6, 7: it.func = FUNC_OFFLINE;
            8, 9: it.func = FUNC_TIME;
            default: it.func = FUNC_RESERVED;
         endcase
      end

      pick = $urandom_range(0, 99);
      if (pick < 84) it.node = node_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 90) it.node = NODE_INVALID;
      else it.node = NODE_W'($urandom_range(0, 65535));

      case ($urandom_range(0, 2))
         0: lit = MODEL_HC;
         1: lit = MODEL_REM;
         default: lit = MODEL_QUAT;
      endcase
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0, 1: it.model = lit;
         // prefix of a known name with junk behind it
         2: begin
            mask = (40'd1 << (8 * $urandom_range(1, 4))) - 40'd1;
            it.model = (lit & mask) | (wide[MODEL_W-1:0] & ~mask);
         end
         default: it.model = wide[MODEL_W-1:0];
      endcase
      it.len = LEN_W'(($urandom_range(0, 99) < 60) ? $urandom_range(0, 8)
                                                   : $urandom_range(0, 255));
      it.present = ($urandom_range(0, 9) != 0);
      it.index = INDEX_W'(($urandom_range(0, 99) < 70) ? $urandom_range(0, TABLE_DEPTH + 1)
                                                       : $urandom_range(0, 255));
      it.value = $urandom;
      return it;
   endfunction

   // result side: random stall before each transfer, one long hold-off
   initial begin : rsp_side
      int stall;
      int taken;
      taken = 0;
      forever begin
         if (taken == HOLD_AT) stall = HOLD_CYCLES;
         else stall = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken++;
      end
   end

   initial begin : stimulus
      int phase;
      int n;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.func <= '0;
      req_ch.node_id <= '0;
      req_ch.model_bytes <= '0;
      req_ch.model_len <= '0;
      req_ch.model_present <= 1'b0;
      req_ch.entry_index <= '0;
      req_ch.time_value <= '0;

      // pool entry 0 is the coordinator id, the rest anything but the coordinator and invalid ids
      node_pool[0] = NODE_COORD;
      for (n = 1; n < POOL_SIZE; n++) node_pool[n] = NODE_W'($urandom_range(1, 65534));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // everything on an empty table misses
      send_op('{FUNC_READ, 16'h1234, '0, 8'd0, 1'b0, 8'd0, 32'd0});
      send_op('{FUNC_LOOKUP, 16'h1234, '0, 8'd0, 1'b0, 8'd0, 32'd0});
      send_op('{FUNC_DELETE, 16'h1234, '0, 8'd0, 1'b0, 8'd0, 32'd0});
      send_op('{FUNC_ONLINE, 16'h1234, '0, 8'd0, 1'b0, 8'd0, 32'd0});
      send_op('{FUNC_RESERVED, 16'h0000, '0, 8'd0, 1'b0, 8'd0, 32'd0});
      // first add stores the coordinator whatever the request says
      send_op('{FUNC_ADD, 16'hFFFF, 40'hFF_FFFF_FFFF, 8'd255, 1'b1, 8'd0, 32'd0});
      // duplicate of the coordinator
      send_op('{FUNC_ADD, 16'h0000, MODEL_HC, 8'd2, 1'b1, 8'd0, 32'd0});
      // invalid id: classified but not stored
      send_op('{FUNC_ADD, 16'hFFFF, MODEL_REM, 8'd3, 1'b1, 8'd0, 32'd0});
      // no model string given
      send_op('{FUNC_ADD, 16'h0001, MODEL_HC, 8'd2, 1'b0, 8'd0, 32'd0});
      send_op('{FUNC_ADD, 16'h0002, MODEL_HC, 8'd2, 1'b1, 8'd0, 32'd0});
      send_op('{FUNC_ADD, 16'h8000, MODEL_REM, 8'd255, 1'b1, 8'd0, 32'd0});
      send_op('{FUNC_ADD, 16'h7FFE, MODEL_QUAT, 8'd5, 1'b1, 8'd0, 32'd0});
      // zero compare length matches the first name
      send_op('{FUNC_ADD, 16'hFFFE, 40'hFF_FFFF_FFFF, 8'd0, 1'b1, 8'd0, 32'd0});
      // "QUxx" within a two byte limit reads as QUAT
      send_op('{FUNC_ADD, 16'h5555, 40'hAA_7878_5551, 8'd2, 1'b1, 8'd0, 32'd0});
      // "HCX" differs at the third byte
      send_op('{FUNC_ADD, 16'hAAAA, 40'h00_0058_4348, 8'd3, 1'b1, 8'd0, 32'd0});
      // read by position: past the end, last filled slot, first empty slot
      send_op('{FUNC_READ, 16'h0000, '0, 8'd0, 1'b0, 8'd255, 32'd0});
      send_op('{FUNC_READ, 16'h0000, '0, 8'd0, 1'b0, 8'd7, 32'd0});
      send_op('{FUNC_READ, 16'h0000, '0, 8'd0, 1'b0, 8'd8, 32'd0});
      send_op('{FUNC_OFFLINE, 16'h8000, '0, 8'd0, 1'b0, 8'd0, 32'd0});
      send_op('{FUNC_TIME, 16'h8000, '0, 8'd0, 1'b0, 8'd0, 32'hFFFF_FFFF});
      send_op('{FUNC_ONLINE, 16'h0002, '0, 8'd0, 1'b0, 8'd0, 32'd0});
      send_op('{FUNC_LOOKUP, 16'h8000, '0, 8'd0, 1'b0, 8'd0, 32'd0});
      // delete from the middle, then read the slot that moved down
      send_op('{FUNC_DELETE, 16'h0002, '0, 8'd0, 1'b0, 8'd0, 32'd0});
      send_op('{FUNC_READ, 16'h0000, '0, 8'd0, 1'b0, 8'd2, 32'd0});
      // the coordinator itself can go
      send_op('{FUNC_DELETE, 16'h0000, '0, 8'd0, 1'b0, 8'd0, 32'd0});

      // --- random part ---
      // fill-heavy, back-to-back mixed, drain-heavy, mixed
      for (phase = 0; phase < 4; phase++) begin
         no_idle <= (phase == 1);
         for (n = 0; n < PHASE_ITEMS; n++)
            send_op(random_op(add_pct[phase], del_pct[phase]));
      end
      req_ch.valid <= 1'b0;

      // wait for the last result, then give a late extra result time to show up
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
